FILE: hw/rtl/rational_arithmetic_unit_defines.svh
// assertion macros for the rational arithmetic unit
`ifndef RATIONAL_ARITHMETIC_UNIT_DEFINES_SVH
`define RATIONAL_ARITHMETIC_UNIT_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define RAU_ASSERT_IMP(label, clk_s, rst_s, ante, cons, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define RAU_ASSERT_NXT(label, clk_s, rst_s, ante, cons, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/rau_pkg.sv
// shared types and codes for the rational arithmetic unit
package rau_pkg;

    // operation codes
    localparam logic [2:0] FUNC_ADD = 3'd0;
    localparam logic [2:0] FUNC_SUB = 3'd1;
    localparam logic [2:0] FUNC_MUL = 3'd2;
    localparam logic [2:0] FUNC_DIV = 3'd3;
    localparam logic [2:0] FUNC_CMP = 3'd4;

    // compare outcome codes
    localparam logic [1:0] ORD_NONE    = 2'd0;
    localparam logic [1:0] ORD_LESS    = 2'd0;
    localparam logic [1:0] ORD_EQUAL   = 2'd1;
    localparam logic [1:0] ORD_GREATER = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_M0,
        S_M1,
        S_M2,
        S_M3,
        S_SUM,
        S_ABS,
        S_STRIP,
        S_GCD,
        S_DIVN,
        S_DIVD,
        S_WAIT
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_sts_t;

endpackage

FILE: hw/rtl/rau_mul.sv
// shared signed multiplier with registered product
module rau_mul
    import rau_pkg::*;
#(
    parameter int WIDTH = 16
)
(
    input  logic                      clk,
    input  logic signed [WIDTH-1:0]   op_a,
    input  logic signed [WIDTH-1:0]   op_b,
    output logic signed [2*WIDTH-1:0] prod
);

    localparam int PW = 2 * WIDTH;

    logic signed [PW-1:0] prod_reg;
    logic signed [PW-1:0] prod_next;

    assign prod_next = PW'(op_a) * PW'(op_b);

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

FILE: hw/rtl/rau_div.sv
// restoring divider, one quotient bit per cycle
module rau_div
    import rau_pkg::*;
#(
    parameter int WIDTH = 32
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [WIDTH-1:0] dividend,
    input  logic [WIDTH-1:0] divisor,
    output logic [WIDTH-1:0] quotient,
    output div_sts_t         sts
);

    localparam int CW = $clog2(WIDTH);
    localparam logic [CW-1:0] LAST = CW'(WIDTH - 1);

    logic [WIDTH-1:0] rem_reg, rem_next;
    logic [WIDTH-1:0] quo_reg, quo_next;
    logic [WIDTH-1:0] dvs_reg, dvs_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [WIDTH:0]   shifted;
    logic [WIDTH:0]   trial;

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        shifted   = {rem_reg, quo_reg[WIDTH-1]};
        trial     = shifted - {1'b0, dvs_reg};
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[WIDTH])
            begin
                rem_next = trial[WIDTH-1:0];
                quo_next = {quo_reg[WIDTH-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[WIDTH-1:0];
                quo_next = {quo_reg[WIDTH-2:0], 1'b0};
            end
            cnt_next = cnt_reg + CW'(1);
            if (cnt_reg == LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
        cnt_reg <= cnt_next;
    end

    assign quotient = quo_reg;
    assign sts.busy = busy_reg;
    assign sts.done = done_reg;

endmodule

FILE: hw/rtl/rational_arithmetic_unit.sv
// rational arithmetic unit: add, subtract, multiply, divide, compare with gcd reduction
// an unused code goes straight to its result, a zero numerator or zero denominator skips the gcd;
// otherwise the run time is set by the binary gcd loop and two passes through the shared divider
// throughput: one transaction at a time; the next is taken once the result is in the output register
// reset: asynchronous active-low, clears the sequencer, the output valid and the divider status only
`include "rational_arithmetic_unit_defines.svh"

module rational_arithmetic_unit
    import rau_pkg::*;
#(
    parameter int DATA_WIDTH = 16
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    // input transaction channel
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [2:0]                   func,
    input  logic signed [DATA_WIDTH-1:0] a_num,
    input  logic signed [DATA_WIDTH-1:0] a_den,
    input  logic signed [DATA_WIDTH-1:0] b_num,
    input  logic signed [DATA_WIDTH-1:0] b_den,
    // result transaction channel
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic signed [2*DATA_WIDTH:0] res_num,
    output logic [2*DATA_WIDTH-2:0]      res_den,
    output logic [1:0]                   order,
    output logic                         zero_den
);

    localparam int W  = DATA_WIDTH;
    localparam int PW = 2 * W;      // cross product width
    localparam int MW = 2 * W;      // magnitude width
    localparam int NW = 2 * W + 1;  // result numerator width
    localparam int DW = 2 * W - 1;  // result denominator width

    // sequencer
    state_t state_reg, state_next;

    // captured operands
    logic [2:0]          func_reg, func_next;
    logic signed [W-1:0] a_num_reg, a_num_next;
    logic signed [W-1:0] a_den_reg, a_den_next;
    logic signed [W-1:0] b_num_reg, b_num_next;
    logic signed [W-1:0] b_den_reg, b_den_next;

    // cross products and signed numerator
    logic signed [PW-1:0] num1_reg, num1_next;
    logic signed [PW-1:0] num2_reg, num2_next;
    logic signed [PW-1:0] den_reg, den_next;
    logic signed [NW-1:0] sum_reg, sum_next;

    // gcd working values and the values to be divided
    logic          n_neg_reg, n_neg_next;
    logic          d_neg_reg, d_neg_next;
    logic [MW-1:0] u_reg, u_next;
    logic [MW-1:0] v_reg, v_next;
    logic [MW-1:0] n_reg, n_next;
    logic [MW-1:0] d_reg, d_next;
    logic [MW-1:0] qn_reg, qn_next;

    // staged result, waiting for the output register
    logic signed [NW-1:0] pend_num_reg, pend_num_next;
    logic [DW-1:0]        pend_den_reg, pend_den_next;
    logic [1:0]           pend_order_reg, pend_order_next;
    logic                 pend_zero_reg, pend_zero_next;

    // output register
    logic                 out_valid_reg, out_valid_next;
    logic signed [NW-1:0] res_num_reg, res_num_next;
    logic [DW-1:0]        res_den_reg, res_den_next;
    logic [1:0]           order_reg, order_next;
    logic                 zero_den_reg, zero_den_next;

    // shared units
    logic signed [W-1:0]  mul_a, mul_b;
    logic signed [PW-1:0] mul_prod;
    logic                 div_start;
    logic [MW-1:0]        div_dividend;
    logic [MW-1:0]        div_quo;
    div_sts_t             div_sts;

    // combinational helpers
    logic                 is_cmp;
    logic                 sum_neg, sum_zero;
    logic                 den_neg, den_zero;
    logic [NW-1:0]        sum_abs;
    logic [PW-1:0]        den_abs;
    logic [MW-1:0]        u_minus_v, v_minus_u;
    logic                 u_ge_v;
    logic                 fin_neg;
    logic [NW-1:0]        fin_mag;
    logic signed [NW-1:0] fin_num;

    rau_mul #(
        .WIDTH (W)
    ) u_mul (
        .clk  (clk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (mul_prod)
    );

    rau_div #(
        .WIDTH (MW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (v_reg),
        .quotient (div_quo),
        .sts      (div_sts)
    );

    // multiplier operand select: one cross product per cycle, product lands in the next cycle
    always_comb
    begin
        mul_a = a_num_reg;
        mul_b = (func_reg == FUNC_MUL) ? b_num_reg : b_den_reg;
        unique case (state_reg)
            S_M1:
            begin
                mul_a = a_den_reg;
                mul_b = b_num_reg;
            end
            S_M2:
            begin
                mul_a = a_den_reg;
                mul_b = (func_reg == FUNC_DIV) ? b_num_reg : b_den_reg;
            end
            default:
            begin
                mul_a = a_num_reg;
                mul_b = (func_reg == FUNC_MUL) ? b_num_reg : b_den_reg;
            end
        endcase
    end

    always_comb
    begin
        is_cmp    = (func_reg == FUNC_CMP);
        sum_neg   = sum_reg[NW-1];
        sum_zero  = (sum_reg == '0);
        sum_abs   = sum_neg ? (~sum_reg + NW'(1)) : sum_reg;
        den_neg   = den_reg[PW-1];
        den_zero  = (den_reg == '0);
        den_abs   = den_neg ? (~den_reg + PW'(1)) : den_reg;
        u_minus_v = u_reg - v_reg;
        v_minus_u = v_reg - u_reg;
        u_ge_v    = (u_reg >= v_reg);
        // sign goes on the numerator; magnitude is nonzero on this path
        fin_neg   = n_neg_reg ^ d_neg_reg;
        fin_mag   = NW'(qn_reg);
        fin_num   = fin_neg ? (~fin_mag + NW'(1)) : fin_mag;
        // numerator is divided first, the denominator right after
        div_dividend = (state_reg == S_GCD) ? n_reg : d_reg;
    end

    // next state and datapath
    always_comb
    begin
        state_next      = state_reg;
        func_next       = func_reg;
        a_num_next      = a_num_reg;
        a_den_next      = a_den_reg;
        b_num_next      = b_num_reg;
        b_den_next      = b_den_reg;
        num1_next       = num1_reg;
        num2_next       = num2_reg;
        den_next        = den_reg;
        sum_next        = sum_reg;
        n_neg_next      = n_neg_reg;
        d_neg_next      = d_neg_reg;
        u_next          = u_reg;
        v_next          = v_reg;
        n_next          = n_reg;
        d_next          = d_reg;
        qn_next         = qn_reg;
        pend_num_next   = pend_num_reg;
        pend_den_next   = pend_den_reg;
        pend_order_next = pend_order_reg;
        pend_zero_next  = pend_zero_reg;
        res_num_next    = res_num_reg;
        res_den_next    = res_den_reg;
        order_next      = order_reg;
        zero_den_next   = zero_den_reg;
        out_valid_next  = out_valid_reg && out_stall;
        div_start       = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    func_next  = func;
                    a_num_next = a_num;
                    a_den_next = a_den;
                    b_num_next = b_num;
                    b_den_next = b_den;
                    if (func > FUNC_CMP)
                    begin
                        // unused code: fixed 0/1 result
                        pend_num_next   = '0;
                        pend_den_next   = DW'(1);
                        pend_order_next = ORD_NONE;
                        pend_zero_next  = 1'b0;
                        state_next      = S_WAIT;
                    end
                    else
                    begin
                        state_next = S_M0;
                    end
                end
            end
            S_M0:
            begin
                state_next = S_M1;
            end
            S_M1:
            begin
                num1_next  = mul_prod;
                state_next = S_M2;
            end
            S_M2:
            begin
                num2_next  = mul_prod;
                state_next = S_M3;
            end
            S_M3:
            begin
                den_next   = mul_prod;
                state_next = S_SUM;
            end
            S_SUM:
            begin
                case (func_reg) inside
                    FUNC_ADD:           sum_next = NW'(num1_reg) + NW'(num2_reg);
                    FUNC_SUB, FUNC_CMP: sum_next = NW'(num1_reg) - NW'(num2_reg);
                    default:            sum_next = NW'(num1_reg);
                endcase
                state_next = S_ABS;
            end
            S_ABS:
            begin
                if (den_zero)
                begin
                    // left unreduced with its own sign
                    pend_num_next  = sum_reg;
                    pend_den_next  = '0;
                    pend_zero_next = 1'b1;
                    if (!is_cmp)
                        pend_order_next = ORD_NONE;
                    else if (sum_neg)
                        pend_order_next = ORD_LESS;
                    else if (sum_zero)
                        pend_order_next = ORD_EQUAL;
                    else
                        pend_order_next = ORD_GREATER;
                    state_next = S_WAIT;
                end
                else if (sum_zero)
                begin
                    // zero over anything reduces to 0/1
                    pend_num_next   = '0;
                    pend_den_next   = DW'(1);
                    pend_zero_next  = 1'b0;
                    pend_order_next = is_cmp ? ORD_EQUAL : ORD_NONE;
                    state_next      = S_WAIT;
                end
                else
                begin
                    n_neg_next = sum_neg;
                    d_neg_next = den_neg;
                    u_next     = sum_abs[MW-1:0];
                    n_next     = sum_abs[MW-1:0];
                    v_next     = den_abs;
                    d_next     = den_abs;
                    state_next = S_STRIP;
                end
            end
            S_STRIP:
            begin
                // common powers of two come off all four values together
                if (!u_reg[0] && !v_reg[0])
                begin
                    u_next = u_reg >> 1;
                    v_next = v_reg >> 1;
                    n_next = n_reg >> 1;
                    d_next = d_reg >> 1;
                end
                else
                begin
                    state_next = S_GCD;
                end
            end
            S_GCD:
            begin
                if (u_reg == '0)
                begin
                    // v holds the odd part of the gcd
                    div_start  = 1'b1;
                    state_next = S_DIVN;
                end
                else if (!u_reg[0])
                begin
                    u_next = u_reg >> 1;
                end
                else if (!v_reg[0])
                begin
                    v_next = v_reg >> 1;
                end
                else if (u_ge_v)
                begin
                    u_next = u_minus_v >> 1;
                end
                else
                begin
                    v_next = v_minus_u >> 1;
                end
            end
            S_DIVN:
            begin
                if (div_sts.done)
                begin
                    qn_next    = div_quo;
                    div_start  = 1'b1;
                    state_next = S_DIVD;
                end
            end
            S_DIVD:
            begin
                if (div_sts.done)
                begin
                    pend_num_next   = fin_num;
                    pend_den_next   = div_quo[DW-1:0];
                    pend_zero_next  = 1'b0;
                    pend_order_next = !is_cmp ? ORD_NONE : (fin_neg ? ORD_LESS : ORD_GREATER);
                    state_next      = S_WAIT;
                end
            end
            S_WAIT:
            begin
                // output register free or draining this cycle
                if (!out_valid_reg || !out_stall)
                begin
                    res_num_next   = pend_num_reg;
                    res_den_next   = pend_den_reg;
                    order_next     = pend_order_reg;
                    zero_den_next  = pend_zero_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg       <= func_next;
        a_num_reg      <= a_num_next;
        a_den_reg      <= a_den_next;
        b_num_reg      <= b_num_next;
        b_den_reg      <= b_den_next;
        num1_reg       <= num1_next;
        num2_reg       <= num2_next;
        den_reg        <= den_next;
        sum_reg        <= sum_next;
        n_neg_reg      <= n_neg_next;
        d_neg_reg      <= d_neg_next;
        u_reg          <= u_next;
        v_reg          <= v_next;
        n_reg          <= n_next;
        d_reg          <= d_next;
        qn_reg         <= qn_next;
        pend_num_reg   <= pend_num_next;
        pend_den_reg   <= pend_den_next;
        pend_order_reg <= pend_order_next;
        pend_zero_reg  <= pend_zero_next;
        res_num_reg    <= res_num_next;
        res_den_reg    <= res_den_next;
        order_reg      <= order_next;
        zero_den_reg   <= zero_den_next;
    end

    // a new transaction is taken only while the sequencer is idle
    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign res_num   = res_num_reg;
    assign res_den   = res_den_reg;
    assign order     = order_reg;
    assign zero_den  = zero_den_reg;

    // checks
    `RAU_ASSERT_IMP(a_den_nonzero, clk, rst_n, out_valid_reg && !zero_den_reg, res_den_reg != '0, "reduced result has a zero denominator")
    `RAU_ASSERT_IMP(a_den_flag, clk, rst_n, out_valid_reg && zero_den_reg, res_den_reg == '0, "zero denominator flag with nonzero denominator")
    `RAU_ASSERT_NXT(a_accept_leaves_idle, clk, rst_n, in_valid && !in_stall, state_reg != S_IDLE, "sequencer idle after accepting a transaction")
    `RAU_ASSERT_IMP(a_div_quiet, clk, rst_n, state_reg == S_STRIP || state_reg == S_GCD, !div_sts.busy, "divider busy during gcd")

endmodule

FILE: tb/rational_arithmetic_unit_checker.sv
// checker for the rational arithmetic unit: predicts each reduced fraction and compares it
`timescale 1ns / 100ps

module rational_arithmetic_unit_checker
    import rau_pkg::*;
#(
    parameter int DATA_WIDTH = 16
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic                         in_stall,
    input  logic [2:0]                   func,
    input  logic signed [DATA_WIDTH-1:0] a_num,
    input  logic signed [DATA_WIDTH-1:0] a_den,
    input  logic signed [DATA_WIDTH-1:0] b_num,
    input  logic signed [DATA_WIDTH-1:0] b_den,
    input  logic                         out_valid,
    input  logic                         out_stall,
    input  logic signed [2*DATA_WIDTH:0] res_num,
    input  logic [2*DATA_WIDTH-2:0]      res_den,
    input  logic [1:0]                   order,
    input  logic                         zero_den,
    output int                           failures,
    output int                           pending
);

    typedef struct packed {
        logic signed [2*DATA_WIDTH:0] num;
        logic [2*DATA_WIDTH-2:0]      den;
        logic [1:0]                   ord;
        logic                         zden;
    } fraction_t;

    fraction_t fractions_due[$];
    int        mismatch_count = 0;

    assign failures = mismatch_count;
    assign pending  = fractions_due.size();

    // cross products, then gcd reduction with the sign moved into the numerator
    function automatic fraction_t reduce_fraction(
        logic [2:0]                   op,
        logic signed [DATA_WIDTH-1:0] an,
        logic signed [DATA_WIDTH-1:0] ad,
        logic signed [DATA_WIDTH-1:0] bn,
        logic signed [DATA_WIDTH-1:0] bd
    );
        longint    n;
        longint    d;
        longint    nmag;
        longint    dmag;
        longint    x;
        longint    y;
        longint    t;
        bit        nneg;
        fraction_t r;
        r.num  = '0;
        r.den  = 1;
        r.ord  = ORD_NONE;
        r.zden = 1'b0;
        if (op > FUNC_CMP)
            return r;
        case (op)
            FUNC_ADD:
            begin
                n = longint'(an) * longint'(bd) + longint'(ad) * longint'(bn);
                d = longint'(ad) * longint'(bd);
            end
            FUNC_SUB, FUNC_CMP:
            begin
                n = longint'(an) * longint'(bd) - longint'(ad) * longint'(bn);
                d = longint'(ad) * longint'(bd);
            end
            FUNC_MUL:
            begin
                n = longint'(an) * longint'(bn);
                d = longint'(ad) * longint'(bd);
            end
            default:
            begin
                n = longint'(an) * longint'(bd);
                d = longint'(ad) * longint'(bn);
            end
        endcase
        nneg = n < 0;
        nmag = nneg ? -n : n;
        if (d == 0)
        begin
            // left unreduced, sign as computed
            r.num  = n[2*DATA_WIDTH:0];
            r.den  = '0;
            r.zden = 1'b1;
        end
        else
        begin
            dmag = (d < 0) ? -d : d;
            x = nmag;
            y = dmag;
            while (y != 0)
            begin
                t = x % y;
                x = y;
                y = t;
            end
            // gcd(0, d) is |d|, which the loop already gives
            nmag = nmag / x;
            dmag = dmag / x;
            nneg = (nmag != 0) && (nneg != (d < 0));
            n = nneg ? -nmag : nmag;
            r.num = n[2*DATA_WIDTH:0];
            r.den = dmag[2*DATA_WIDTH-2:0];
        end
        if (op == FUNC_CMP)
            r.ord = nneg ? ORD_LESS : ((nmag == 0) ? ORD_EQUAL : ORD_GREATER);
        return r;
    endfunction

    task automatic report_field(string field, logic signed [63:0] want,
                                logic signed [63:0] got);
        mismatch_count++;
        $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
    endtask

    always @(posedge clk)
    begin
        fraction_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (fractions_due.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t: result transaction with none expected, got %0d/%0d",
                             $time, res_num, res_den);
                end
                else
                begin
                    want = fractions_due.pop_front();
                    if (res_num !== want.num)
                        report_field("res_num", want.num, $signed(res_num));
                    if (res_den !== want.den)
                        report_field("res_den", want.den, res_den);
                    if (order !== want.ord)
                        report_field("order", want.ord, order);
                    if (zero_den !== want.zden)
                        report_field("zero_den", want.zden, zero_den);
                end
            end
            if (in_valid && !in_stall)
                fractions_due.push_back(reduce_fraction(func, a_num, a_den, b_num, b_den));
        end
    end

endmodule

FILE: tb/rational_arithmetic_unit_test.sv
// top of the rational arithmetic unit testbench: stimulus, flow control and verdict
`timescale 1ns / 100ps

module rational_arithmetic_unit_test;
    import rau_pkg::*;

    localparam int DATA_WIDTH = 16;

    // operation codes the block does not define; they must give 0/1
    localparam logic [2:0] FUNC_SPARE_FIRST = FUNC_CMP + 3'd1;
    localparam logic [2:0] FUNC_SPARE_LAST  = 3'd7;

    localparam int RANDOM_OPS  = 1530;
    // a little more than the slowest reduction path
    localparam int DRAIN_CYCLES = 160;

    logic                         clk;
    logic                         rst_n;
    logic                         in_valid;
    logic                         in_stall;
    logic [2:0]                   func;
    logic signed [DATA_WIDTH-1:0] a_num;
    logic signed [DATA_WIDTH-1:0] a_den;
    logic signed [DATA_WIDTH-1:0] b_num;
    logic signed [DATA_WIDTH-1:0] b_den;
    logic                         out_valid;
    logic                         out_stall;
    logic signed [2*DATA_WIDTH:0] res_num;
    logic [2*DATA_WIDTH-2:0]      res_den;
    logic [1:0]                   order;
    logic                         zero_den;

    int failures;
    int pending;
    // while set, neither side idles, so transactions go back to back
    bit calm = 1'b0;

    rational_arithmetic_unit #(
        .DATA_WIDTH(DATA_WIDTH)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .func     (func),
        .a_num    (a_num),
        .a_den    (a_den),
        .b_num    (b_num),
        .b_den    (b_den),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .res_num  (res_num),
        .res_den  (res_den),
        .order    (order),
        .zero_den (zero_den)
    );

    rational_arithmetic_unit_checker #(
        .DATA_WIDTH(DATA_WIDTH)
    ) result_check (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .func     (func),
        .a_num    (a_num),
        .a_den    (a_den),
        .b_num    (b_num),
        .b_den    (b_den),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .res_num  (res_num),
        .res_den  (res_den),
        .order    (order),
        .zero_den (zero_den),
        .failures (failures),
        .pending  (pending)
    );

    // 8 ns clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // gap length: mostly none or short, now and then a long one
    function automatic int idle_cycles();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 20);
        return $urandom_range(50, 300);
    endfunction

    // operand mix: full range for bit coverage, small values so gcds are
    // nontrivial and zeros show up, and the corner values
    function automatic logic signed [DATA_WIDTH-1:0] pick_operand();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0:
            begin
                case ($urandom_range(0, 4))
                    0:       return {1'b1, {(DATA_WIDTH-1){1'b0}}};
                    1:       return {1'b0, {(DATA_WIDTH-1){1'b1}}};
                    2:       return '0;
                    3:       return '1;
                    default: return 1;
                endcase
            end
            1, 2, 3: return $urandom_range(0, 40) - 20;
            4, 5:    return ($urandom_range(0, 200) - 100) * 12;
            default: return $urandom();
        endcase
    endfunction

    // present one input transaction and hold it until the block takes it;
    // valid stays high across back-to-back transactions
    task automatic issue_operation(
        logic [2:0]                   op,
        logic signed [DATA_WIDTH-1:0] an,
        logic signed [DATA_WIDTH-1:0] ad,
        logic signed [DATA_WIDTH-1:0] bn,
        logic signed [DATA_WIDTH-1:0] bd
    );
        int gap;
        gap = calm ? 0 : idle_cycles();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        func     <= op;
        a_num    <= an;
        a_den    <= ad;
        b_num    <= bn;
        b_den    <= bd;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // result side: random stall bursts, none while calm
    initial
    begin
        int n;
        out_stall <= 1'b0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            n = calm ? 0 : idle_cycles();
            if (n > 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // run limit: far beyond the slowest legal run with every stall at its longest
    initial
    begin
        #40_000_000;
        $display("FAIL");
        $finish;
    end

    initial
    begin
        logic [2:0] op;
        rst_n    = 1'b0;
        in_valid <= 1'b0;
        func     <= FUNC_ADD;
        a_num    <= '0;
        a_den    <= '0;
        b_num    <= '0;
        b_den    <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: add, subtract, multiply and divide on plain fractions
        issue_operation(FUNC_ADD, 1, 2, 1, 3);
        issue_operation(FUNC_SUB, 1, 2, 1, 3);
        issue_operation(FUNC_MUL, 6, 35, 14, 15);
        issue_operation(FUNC_DIV, 3, 4, 9, 8);
        // compare: less, equal (unreduced operands), greater
        issue_operation(FUNC_CMP, 1, 3, 1, 2);
        issue_operation(FUNC_CMP, 1, 2, 2, 4);
        issue_operation(FUNC_CMP, 5, 7, -5, 7);
        // negative denominators, sign goes to the numerator
        issue_operation(FUNC_ADD, 1, -2, 1, -3);
        issue_operation(FUNC_MUL, -3, -4, 2, -9);
        // corner values: largest cross-product sum, most negative operands
        issue_operation(FUNC_ADD, -32768, -32768, -32768, -32768);
        issue_operation(FUNC_SUB, -32768, 32767, 32767, -32768);
        issue_operation(FUNC_MUL, 32767, 32767, -32768, 1);
        issue_operation(FUNC_DIV, -32768, 1, -32768, 32767);
        // zero numerator reduces to 0/1
        issue_operation(FUNC_MUL, 0, 5, 3, 7);
        issue_operation(FUNC_SUB, 4, 6, 2, 3);
        // zero denominator: flag set, numerator left unreduced
        issue_operation(FUNC_ADD, 3, 0, 1, 2);
        issue_operation(FUNC_DIV, 1, 2, 0, 3);
        issue_operation(FUNC_ADD, -32768, 0, 5, -32768);
        // compare under a zero denominator follows the raw numerator sign
        issue_operation(FUNC_CMP, -3, 2, 1, 0);
        issue_operation(FUNC_CMP, 3, 0, -1, 2);
        issue_operation(FUNC_CMP, 0, 0, 0, 0);
        // undefined operation codes
        issue_operation(FUNC_SPARE_FIRST, 7, 3, -2, 9);
        issue_operation(3'd6, -32768, 0, 32767, 0);
        issue_operation(FUNC_SPARE_LAST, 1, 1, 1, 1);

        // hold off until the block has returned everything
        in_valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        @(posedge clk);

        for (int i = 0; i < RANDOM_OPS; i++)
        begin
            // a stretch of a hundred transactions with no idling in every four hundred
            calm = (i % 400) >= 300;
            if ($urandom_range(0, 19) == 0)
                op = $urandom_range(FUNC_SPARE_FIRST, FUNC_SPARE_LAST);
            else
                op = $urandom_range(FUNC_ADD, FUNC_CMP);
            issue_operation(op, pick_operand(), pick_operand(), pick_operand(),
                            pick_operand());
            // now and then drain the pipeline completely
            if (i % 500 == 499)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
                wait (pending == 0);
                @(posedge clk);
            end
        end
        calm = 1'b0;

        // stimulus done: wait for the last results, then some slack for strays
        in_valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (failures == 0 && pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/rau_pkg.sv
hw/rtl/rau_mul.sv
hw/rtl/rau_div.sv
hw/rtl/rational_arithmetic_unit.sv
tb/rational_arithmetic_unit_checker.sv
tb/rational_arithmetic_unit_test.sv
